// ----- sv/mtf_pkg.sv -----
// Shared types and constants for the move-to-front list.
// No dependencies; imported by mtf_cell, mtf_ctrl, move_to_front_list_top, mtf_list_checker and the testbench.
package mtf_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 6;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_LOOKUP = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPARE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic append;
        logic compare;
        logic scan;
        logic shift;
    } t_cell_ctl;

endpackage

// ----- sv/mtf_cell.sv -----
// One list cell: holds an entry and its match flag, talks to its neighbours.
// Depends on mtf_pkg.
module mtf_cell #(
    parameter int IDX   = 0,
    parameter int DEPTH = mtf_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mtf_pkg::t_cell_ctl                i_ctl,
    input  logic [CNT_W-1:0]                  i_count,
    input  logic [IDX_W-1:0]                  i_pos,
    input  logic signed [mtf_pkg::KEY_W-1:0]  i_key,
    input  logic signed [mtf_pkg::KEY_W-1:0]  i_wdata,
    input  logic signed [mtf_pkg::KEY_W-1:0]  i_prev_value,
    input  logic                              i_next_match,
    output logic signed [mtf_pkg::KEY_W-1:0]  o_value,
    output logic                              o_match
);
    import mtf_pkg::*;

    logic signed [KEY_W-1:0] r_value;
    logic                    r_match;
    logic                    in_range;
    logic                    shift_en;
    logic                    write_en;

    assign in_range = CNT_W'(IDX) < i_count;
    assign shift_en = IDX_W'(IDX) <= i_pos;
    assign write_en = i_ctl.append && (CNT_W'(IDX) == i_count);

    always_ff @(posedge i_clk) begin
        if (write_en) begin
            r_value <= i_wdata;
        end else if (i_ctl.shift && shift_en) begin
            r_value <= i_prev_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.compare) begin
            r_match <= in_range && (r_value == i_key);
        end else if (i_ctl.scan) begin
            r_match <= i_next_match;
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ----- sv/mtf_ctrl.sv -----
// Sequencer for the cell chain: handshakes, entry count, scan index, result register.
// Depends on mtf_pkg.
module mtf_ctrl #(
    parameter int DEPTH = mtf_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mtf_pkg::t_opcode                  i_opcode,
    input  logic signed [mtf_pkg::KEY_W-1:0]  i_key_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [mtf_pkg::POS_W-1:0]         o_position,
    input  logic                              i_head_match,
    output mtf_pkg::t_cell_ctl                o_ctl,
    output logic [CNT_W-1:0]                  o_count,
    output logic [IDX_W-1:0]                  o_scan_idx,
    output logic signed [mtf_pkg::KEY_W-1:0]  o_key
);
    import mtf_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_count;
    logic [IDX_W-1:0]        r_scan_idx;
    logic signed [KEY_W-1:0] r_key;
    logic                    r_found;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic [POS_W-1:0]        r_out_pos;

    logic in_acc;
    logic not_full;
    logic scan_last;
    logic out_free;

    assign not_full  = r_count < CNT_W'(DEPTH);
    assign scan_last = (CNT_W'(r_scan_idx) + CNT_W'(1)) >= r_count;
    assign out_free  = !r_out_valid || i_out_ready;
    assign in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_LOOKUP)) begin
                    n_state = S_COMPARE;
                end
            end
            S_COMPARE: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_head_match) begin
                    n_state = S_SHIFT;
                end else if (scan_last) begin
                    n_state = S_RESULT;
                end
            end
            S_SHIFT: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_ctl.append   = i_in_valid && (r_state == S_IDLE) && (i_opcode == OP_APPEND)
                         && not_full;
        o_ctl.compare  = (r_state == S_COMPARE);
        o_ctl.scan     = (r_state == S_SCAN) && !i_head_match && !scan_last;
        o_ctl.shift    = (r_state == S_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key <= i_key_value;
        end
        if (r_state == S_COMPARE) begin
            r_scan_idx <= '0;
        end else if (o_ctl.scan) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        if (r_state == S_SCAN) begin
            r_found <= i_head_match;
        end
        if ((r_state == S_RESULT) && out_free) begin
            r_out_found <= r_found;
            r_out_pos   <= r_found ? POS_W'(r_scan_idx) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;
    assign o_count     = r_count;
    assign o_scan_idx  = r_scan_idx;
    assign o_key       = r_key;

endmodule

// ----- sv/move_to_front_list_top.sv -----
// Append: one per cycle while idle, no result. Lookup: the key is compared in every cell
// at once, then the match flags march one cell a cycle towards the head; a hit at position p
// moves that entry to the front and reports p, a miss ends the scan at the last entry.
// The next transaction is taken once the result sits in the output register.
// Reset clears the entry count and the control state; entries stay undefined until written.
module move_to_front_list_top #(
    parameter int DEPTH = mtf_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mtf_pkg::t_opcode                  i_opcode,
    input  logic signed [mtf_pkg::KEY_W-1:0]  i_key_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [mtf_pkg::POS_W-1:0]         o_position
);
    import mtf_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cell_ctl               ctl;
    logic [CNT_W-1:0]        count;
    logic [IDX_W-1:0]        scan_idx;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] cell_value [DEPTH];
    logic                    cell_match [DEPTH];

    mtf_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_key_value  (i_key_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_position   (o_position),
        .i_head_match (cell_match[0]),
        .o_ctl        (ctl),
        .o_count      (count),
        .o_scan_idx   (scan_idx),
        .o_key        (key)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [KEY_W-1:0] prev_value;
        logic                    next_match;

        if (g == 0) begin : g_head
            assign prev_value = key;
        end else begin : g_body
            assign prev_value = cell_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_match = 1'b0;
        end else begin : g_inner
            assign next_match = cell_match[g+1];
        end

        mtf_cell #(
            .IDX   (g),
            .DEPTH (DEPTH),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_count      (count),
            .i_pos        (scan_idx),
            .i_key        (key),
            .i_wdata      (i_key_value),
            .i_prev_value (prev_value),
            .i_next_match (next_match),
            .o_value      (cell_value[g]),
            .o_match      (cell_match[g])
        );
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == OP_APPEND) && (count < CNT_W'(DEPTH)))
        |=> (count == $past(count) + CNT_W'(1)))
        else $error("append did not grow the list");

    a_lookup_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == OP_LOOKUP)) |=> $stable(count))
        else $error("lookup changed the entry count");

    a_shift_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.shift |-> $past(cell_match[0]))
        else $error("move to front without a hit at the head");
`endif

endmodule

// ----- test/mtf_list_checker.sv -----
// Checker for the move-to-front list: watches both channels, keeps its own copy of the list
// and compares every lookup result with the predicted one. Depends on mtf_pkg.
module mtf_list_checker #(
    parameter int DEPTH = mtf_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  mtf_pkg::t_opcode                  i_opcode,
    input  logic signed [mtf_pkg::KEY_W-1:0]  i_key_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_found,
    input  logic [mtf_pkg::POS_W-1:0]         i_position,
    output int                                o_err_count,
    output int                                o_pending
);
    import mtf_pkg::*;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_lookup_res;

    logic signed [KEY_W-1:0] shadow_list [DEPTH];
    int                      shadow_count;
    t_lookup_res             lookup_q [$];

    function automatic t_lookup_res search_and_promote(logic signed [KEY_W-1:0] key);
        t_lookup_res res;
        int          hit;
        res = '0;
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_list[i] == key) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            for (int i = hit; i > 0; i--) begin
                shadow_list[i] = shadow_list[i-1];
            end
            shadow_list[0] = key;
            res.found      = 1'b1;
            res.position   = POS_W'(hit);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_res want;
        if (!i_rst_n) begin
            shadow_count = 0;
            o_err_count  = 0;
            lookup_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (lookup_q.size() == 0) begin
                    $error("unexpected result: found %0b position %0d", i_found, i_position);
                    o_err_count++;
                end else begin
                    want = lookup_q.pop_front();
                    if (i_found !== want.found) begin
                        $error("found: expected %0b, actual %0b", want.found, i_found);
                        o_err_count++;
                    end
                    if (i_position !== want.position) begin
                        $error("position: expected %0d, actual %0d", want.position, i_position);
                        o_err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_opcode == OP_APPEND) begin
                    if (shadow_count < DEPTH) begin
                        shadow_list[shadow_count] = i_key_value;
                        shadow_count++;
                    end
                end else begin
                    lookup_q.push_back(search_and_promote(i_key_value));
                end
            end
        end
        o_pending = lookup_q.size();
    end

endmodule

// ----- test/tb_move_to_front_list_top.sv -----
// Testbench top for move_to_front_list_top: drives appends and lookups with random idling on
// both channels and gives the verdict. Depends on mtf_pkg, the block and mtf_list_checker.
module tb_move_to_front_list_top;
    import mtf_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int N_RANDOM  = 1630;
    localparam int N_TOTAL   = N_RANDOM + 18;
    localparam int DRAIN_CYC = DEPTH + 40;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    t_opcode                 i_opcode;
    logic signed [KEY_W-1:0] i_key_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_found;
    logic [POS_W-1:0]        o_position;

    int                      err_count;
    int                      pending;
    int                      send_idle_pct;
    int                      recv_idle_pct;
    int                      sent_items;
    logic signed [KEY_W-1:0] stored_keys [$];

    move_to_front_list_top #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_key_value (i_key_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_position  (o_position)
    );

    mtf_list_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_key_value (i_key_value),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_found     (o_found),
        .i_position  (o_position),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    initial begin
        #(8 * 2_000_000);
        $display("tb_move_to_front_list_top: FAIL");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [KEY_W-1:0] near_zero_key();
        return KEY_W'($signed($urandom_range(0, 7)) - 4);
    endfunction

    task automatic send_item(t_opcode op, logic signed [KEY_W-1:0] key);
        if (sent_items == N_TOTAL / 3) begin
            send_idle_pct = 83;
            recv_idle_pct = 7;
        end else if (sent_items == 2 * N_TOTAL / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_key_value <= key;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (op == OP_APPEND && stored_keys.size() < DEPTH) begin
            stored_keys.push_back(key);
        end
        sent_items++;
        @(negedge i_clk);
    endtask

    initial begin
        logic signed [KEY_W-1:0] key;
        int                      pick;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_APPEND;
        i_key_value   = '0;
        send_idle_pct = 7;
        recv_idle_pct = 83;
        sent_items    = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // lookups on an empty list
        send_item(OP_LOOKUP, 32'sd0);
        send_item(OP_LOOKUP, 32'sh8000_0000);
        send_item(OP_APPEND, 32'sh8000_0000);
        send_item(OP_APPEND, 32'sh7fff_ffff);
        send_item(OP_APPEND, 32'sd0);
        send_item(OP_APPEND, -32'sd1);
        send_item(OP_APPEND, 32'sh5555_5555);
        send_item(OP_APPEND, 32'shaaaa_aaaa);
        send_item(OP_APPEND, -32'sd1);
        // duplicate: the copy nearer the front wins, then a hit at the front
        send_item(OP_LOOKUP, -32'sd1);
        send_item(OP_LOOKUP, -32'sd1);
        send_item(OP_LOOKUP, 32'sh7fff_ffff);
        send_item(OP_LOOKUP, 32'shaaaa_aaaa);
        send_item(OP_LOOKUP, 32'sd12345);
        send_item(OP_LOOKUP, 32'sh8000_0001);
        send_item(OP_LOOKUP, 32'shffff_fffe);
        send_item(OP_LOOKUP, 32'sh8000_0000);
        send_item(OP_LOOKUP, 32'sd0);

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) begin
                key = (pick < 3) ? near_zero_key() : $urandom;
                send_item(OP_APPEND, key);
            end else begin
                if (pick < 7 && stored_keys.size() > 0) begin
                    key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                end else if (pick == 7) begin
                    key = near_zero_key();
                end else begin
                    key = $urandom;
                end
                send_item(OP_LOOKUP, key);
            end
        end
        i_in_valid <= 1'b0;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("tb_move_to_front_list_top: PASS");
        end else begin
            $display("tb_move_to_front_list_top: FAIL");
        end
        $finish;
    end

endmodule
